/* rtl/spt_pkg.sv */
package spt_pkg;

	// register indexes of the configuration port
	localparam logic [2:0] REG_INITIAL_DELAY = 3'd0;
	localparam logic [2:0] REG_GAP           = 3'd1;
	localparam logic [2:0] REG_WIDTH         = 3'd2;
	localparam logic [2:0] REG_AMPLITUDE     = 3'd3;
	localparam logic [2:0] REG_REPEAT        = 3'd4;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 48;
	localparam int REPEAT_BITS    = 17;

	// repeat count after reset: a single period
	localparam logic signed [REPEAT_BITS-1:0] REPEAT_RESET = 17'sd1;

	// divider status toward the top level
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

/* rtl/spt_cfg_regs.sv */
module spt_cfg_regs #(
	parameter int TIME_BITS  = 32,
	parameter int LEVEL_BITS = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     wr_en,
	input  logic [spt_pkg::CFG_INDEX_BITS-1:0]       wr_index,
	input  logic [spt_pkg::CFG_DATA_BITS-1:0]        wr_data,
	output logic [TIME_BITS-1:0]                     delay_q,
	output logic [TIME_BITS-1:0]                     gap_q,
	output logic [TIME_BITS-1:0]                     width_q,
	output logic signed [LEVEL_BITS-1:0]             amp_q,
	output logic signed [spt_pkg::REPEAT_BITS-1:0]   repeat_q,
	output logic                                     resync
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q  <= '0;
			gap_q    <= '0;
			width_q  <= '0;
			amp_q    <= '0;
			repeat_q <= spt_pkg::REPEAT_RESET;
		end else if (wr_en) begin
			case (wr_index)
				spt_pkg::REG_INITIAL_DELAY: delay_q  <= wr_data[TIME_BITS-1:0];
				spt_pkg::REG_GAP:           gap_q    <= wr_data[TIME_BITS-1:0];
				spt_pkg::REG_WIDTH:         width_q  <= wr_data[TIME_BITS-1:0];
				spt_pkg::REG_AMPLITUDE:     amp_q    <= wr_data[LEVEL_BITS-1:0];
				spt_pkg::REG_REPEAT:        repeat_q <= wr_data[spt_pkg::REPEAT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// timing registers change the phase/period position
	always_comb begin
		resync = 1'b0;
		if (wr_en) begin
			case (wr_index)
				spt_pkg::REG_INITIAL_DELAY,
				spt_pkg::REG_GAP,
				spt_pkg::REG_WIDTH: resync = 1'b1;
				default: resync = 1'b0;
			endcase
		end
	end

endmodule

/* rtl/spt_phase_div.sv */
module spt_phase_div #(
	parameter int TIME_BITS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [TIME_BITS-1:0]     dividend,
	input  logic [TIME_BITS:0]       divisor,
	output logic [TIME_BITS-1:0]     quot,
	output logic [TIME_BITS:0]       rem,
	output spt_pkg::div_stat_t       stat
);

	localparam int CNT_BITS = $clog2(TIME_BITS + 1);
	localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(TIME_BITS - 1);

	logic [TIME_BITS:0]     rem_q;
	logic [TIME_BITS-1:0]   quo_q;
	logic [TIME_BITS:0]     div_q;
	logic [CNT_BITS-1:0]    cnt_q;
	logic                   busy_q;
	logic                   done_q;

	logic [TIME_BITS+1:0]   shifted;
	logic                   fits;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	assign shifted = {rem_q, quo_q[TIME_BITS-1]};
	assign fits    = shifted >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (TIME_BITS+1)'(shifted - {1'b0, div_q})
			              : shifted[TIME_BITS:0];
			quo_q <= {quo_q[TIME_BITS-2:0], fits};
		end
	end

	assign quot      = quo_q;
	assign rem       = rem_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

/* rtl/square_pulse_train_generator.sv */
// square pulse train generator, one result per accepted tick
// drive_level / pulse_active are registered in the cycle after a request is accepted
// throughput: one request per cycle when the result slot is free or drained and no
//   configuration write is made; a write to delay, gap or width re-derives the phase
//   and period counters with a bit-serial divider, holding off requests until it is done
// reset (arst_n low): elapsed time and counters clear, registers take their reset values
module square_pulse_train_generator #(
	parameter int TIME_BITS  = 32,
	parameter int LEVEL_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write channel
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [spt_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [spt_pkg::CFG_DATA_BITS-1:0]     cfg_data,
	// tick request channel
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  restart,
	// result channel
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [LEVEL_BITS-1:0]          drive_level,
	output logic                                  pulse_active
);

	localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

	// configuration registers
	logic [TIME_BITS-1:0]                      delay_q;
	logic [TIME_BITS-1:0]                      gap_q;
	logic [TIME_BITS-1:0]                      width_q;
	logic signed [LEVEL_BITS-1:0]              amp_q;
	logic signed [spt_pkg::REPEAT_BITS-1:0]    repeat_q;
	logic                                      resync;
	logic                                      resync_q;
	logic                                      cfg_fire;

	// tick state: elapsed time and, for that time, phase within the period
	// and index of the period (only meaningful once past the initial delay)
	logic [TIME_BITS-1:0]   elapsed_q;
	logic [TIME_BITS:0]     phase_q;
	logic [TIME_BITS-1:0]   periods_q;

	// divider
	logic [TIME_BITS-1:0]   div_quot;
	logic [TIME_BITS:0]     div_rem;
	spt_pkg::div_stat_t     div_stat;

	// result register
	logic                           out_valid_q;
	logic signed [LEVEL_BITS-1:0]   level_q;
	logic                           active_q;

	// per-tick evaluation
	logic                   in_fire;
	logic [TIME_BITS:0]     period;
	logic [TIME_BITS-1:0]   eval_t;
	logic                   past_delay;
	logic                   at_delay;
	logic                   saturated;
	logic                   rep_forever;
	logic                   rep_neg;
	logic                   in_count;
	logic                   active;
	logic                   period_end;
	logic                   unit_period;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid & cfg_ready;

	spt_cfg_regs #(
		.TIME_BITS  (TIME_BITS),
		.LEVEL_BITS (LEVEL_BITS)
	) u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_fire),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.delay_q  (delay_q),
		.gap_q    (gap_q),
		.width_q  (width_q),
		.amp_q    (amp_q),
		.repeat_q (repeat_q),
		.resync   (resync)
	);

	assign period = {1'b0, gap_q} + {1'b0, width_q};

	// divider starts in the cycle after the timing write, once the new values
	// sit in the registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resync_q <= 1'b0;
		end else begin
			resync_q <= resync;
		end
	end

	// re-derive phase and period index for the current elapsed time after a
	// timing change; the result is loaded even when elapsed time is not past the delay
	spt_phase_div #(
		.TIME_BITS (TIME_BITS)
	) u_phase_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (resync_q),
		.dividend (elapsed_q - delay_q),
		.divisor  (period),
		.quot     (div_quot),
		.rem      (div_rem),
		.stat     (div_stat)
	);

	// take a request while the result slot is free or being drained; no request during
	// a configuration write, nor from a timing write until the divider result is loaded
	assign in_ready = !resync_q && !div_stat.busy && !div_stat.done && !cfg_fire &&
		(!out_valid_q || out_ready);
	assign in_fire  = in_valid & in_ready;

	// restart clears elapsed time before this tick is evaluated
	assign eval_t     = restart ? '0 : elapsed_q;
	assign past_delay = eval_t > delay_q;
	assign at_delay   = eval_t == delay_q;
	assign saturated  = eval_t == TIME_MAX;

	// repeat count: all ones is forever, other negatives never qualify, zero is off
	assign rep_forever = &repeat_q;
	assign rep_neg     = repeat_q[spt_pkg::REPEAT_BITS-1];
	assign in_count    = rep_forever ||
		(!rep_neg && ({{spt_pkg::REPEAT_BITS{1'b0}}, periods_q} <
		              {{TIME_BITS{1'b0}}, repeat_q}));

	assign active = past_delay && (period != '0) && (repeat_q != '0) &&
		(phase_q >= {1'b0, gap_q}) && in_count;

	assign period_end  = (phase_q + 1'b1) == period;
	assign unit_period = period == (TIME_BITS+1)'(1);

	// elapsed time and phase/period counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			phase_q   <= '0;
			periods_q <= '0;
		end else if (in_fire) begin
			if (!saturated) begin
				elapsed_q <= eval_t + 1'b1;
				if (past_delay) begin
					// one tick further into the train
					if (period_end) begin
						phase_q   <= '0;
						periods_q <= periods_q + 1'b1;
					end else begin
						phase_q <= phase_q + 1'b1;
					end
				end else if (at_delay) begin
					// next tick is the first one after the delay
					phase_q   <= unit_period ? '0 : (TIME_BITS+1)'(1);
					periods_q <= unit_period ? (TIME_BITS)'(1) : '0;
				end
			end else begin
				elapsed_q <= eval_t;
			end
		end else if (div_stat.done) begin
			phase_q   <= div_rem;
			periods_q <= div_quot;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			level_q  <= active ? amp_q : '0;
			active_q <= active;
		end
	end

	assign out_valid    = out_valid_q;
	assign drive_level  = level_q;
	assign pulse_active = active_q;

endmodule
